/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while in reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ilmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ilmc_pkg;

  localparam int LEVEL_W     = 7;
  localparam int STEP_W      = 6;
  localparam int INTERVAL_W  = 10;
  localparam int DELAY_W     = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam int POLL_TICKS_DEFAULT = 5;

  // register defaults
  localparam logic [LEVEL_W-1:0]    MIN_LEVEL_RST       = 7'd10;
  localparam logic [LEVEL_W-1:0]    MAX_LEVEL_RST       = 7'd100;
  localparam logic [LEVEL_W-1:0]    LOW_LEVEL_RST       = 7'd20;
  localparam logic [STEP_W-1:0]     RAMP_STEP_RST       = 6'd5;
  localparam logic [INTERVAL_W-1:0] RAMP_INTERVAL_RST   = 10'd20;
  localparam logic [DELAY_W-1:0]    IDLE_OFF_RST        = 16'd5000;
  localparam logic [DELAY_W-1:0]    FLASH_ON_RST        = 16'd100;
  localparam logic [DELAY_W-1:0]    FLASH_PERIOD_RST    = 16'd1000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_LEVEL     = 4'd0,
    REG_MAX_LEVEL     = 4'd1,
    REG_LOW_LEVEL     = 4'd2,
    REG_RAMP_STEP     = 4'd3,
    REG_RAMP_INTERVAL = 4'd4,
    REG_IDLE_OFF      = 4'd5,
    REG_FLASH_ON      = 4'd6,
    REG_FLASH_PERIOD  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                  touched;
    logic                  keys_active;
    logic [LEVEL_W-1:0]    backlight_level;
    logic                  usb_link;
    logic                  caps_lock;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]    led_level;
    logic                  led_written;
  } result_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]    min_level;
    logic [LEVEL_W-1:0]    max_level;
    logic [LEVEL_W-1:0]    low_level;
    logic [STEP_W-1:0]     ramp_step;
    logic [INTERVAL_W-1:0] ramp_interval_ms;
    logic [DELAY_W-1:0]    idle_off_ms;
    logic [DELAY_W-1:0]    flash_lit_ms;
    logic [DELAY_W-1:0]    flash_period_ms;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/indicator_led_mode_controller.sv */
// indicator led mode controller, one item per tick
// path: the item is held in the input register, its result in the result register
// throughput: one item per cycle unless the result stalls, by a single registered pass
// stalls: at most two items held (input and result registers) while the result waits
// reset: synchronous; valid flags and tick state reset at once, data registers do not
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module indicator_led_mode_controller #(
  parameter int POLL_TICKS = ilmc_pkg::POLL_TICKS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output      logic                              item_ready,
  input  wire ilmc_pkg::item_t                   item,
  output      logic                              result_valid,
  input  wire logic                              result_ready,
  output      ilmc_pkg::result_t                 result,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [ilmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ilmc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ilmc_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  logic    advance;
  result_t result_d;

  ilmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input stage moves on when the result register is free or being emptied
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  ilmc_core #(
    .POLL_TICKS (POLL_TICKS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (item_q),
    .cfg         (cfg),
    .result_next (result_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_d;
    end
  end

  // every processed item leaves a result behind
  `ASSERT_CLK(a_advance_gives_result, clk, rst, advance |=> result_valid,
              "processed item produced no result")

endmodule

`default_nettype wire

/* rtl/ilmc_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module ilmc_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [ilmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ilmc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output      ilmc_pkg::cfg_t                      cfg
);
  import ilmc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_level        <= MIN_LEVEL_RST;
      cfg.max_level        <= MAX_LEVEL_RST;
      cfg.low_level        <= LOW_LEVEL_RST;
      cfg.ramp_step        <= RAMP_STEP_RST;
      cfg.ramp_interval_ms <= RAMP_INTERVAL_RST;
      cfg.idle_off_ms      <= IDLE_OFF_RST;
      cfg.flash_lit_ms     <= FLASH_ON_RST;
      cfg.flash_period_ms  <= FLASH_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      // unknown indexes are dropped
      unique case (cfg_index)
        REG_MIN_LEVEL:     cfg.min_level        <= cfg_data[LEVEL_W-1:0];
        REG_MAX_LEVEL:     cfg.max_level        <= cfg_data[LEVEL_W-1:0];
        REG_LOW_LEVEL:     cfg.low_level        <= cfg_data[LEVEL_W-1:0];
        REG_RAMP_STEP:     cfg.ramp_step        <= cfg_data[STEP_W-1:0];
        REG_RAMP_INTERVAL: cfg.ramp_interval_ms <= cfg_data[INTERVAL_W-1:0];
        REG_IDLE_OFF:      cfg.idle_off_ms      <= cfg_data[DELAY_W-1:0];
        REG_FLASH_ON:      cfg.flash_lit_ms     <= cfg_data[DELAY_W-1:0];
        REG_FLASH_PERIOD:  cfg.flash_period_ms  <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/ilmc_core.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ilmc_core #(
  parameter int POLL_TICKS = ilmc_pkg::POLL_TICKS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire ilmc_pkg::item_t    item,
  input  wire ilmc_pkg::cfg_t     cfg,
  output      ilmc_pkg::result_t  result_next
);
  import ilmc_pkg::*;

  localparam int POLL_W = $clog2(POLL_TICKS + 1);
  localparam logic [POLL_W-1:0] POLL_RELOAD = POLL_W'(POLL_TICKS - 1);

  // tick state
  logic                  caps_mode, caps_mode_next;
  logic                  touch_held, touch_held_next;
  logic                  ramp_rising, ramp_rising_next;
  logic                  keys_seen_active, keys_seen_active_next;
  logic                  usb_flash_mode, usb_flash_mode_next;
  logic                  flash_phase_on, flash_phase_on_next;
  logic [LEVEL_W-1:0]    ramp_level, ramp_level_next;
  logic [LEVEL_W-1:0]    shown_level, shown_level_next;
  logic [LEVEL_W-1:0]    seen_backlight, seen_backlight_next;
  logic [LEVEL_W-1:0]    led_reg, led_reg_next;
  logic [INTERVAL_W-1:0] ramp_timer, ramp_timer_next;
  logic [DELAY_W-1:0]    idle_timer, idle_timer_next;
  logic [DELAY_W-1:0]    flash_timer, flash_timer_next;
  logic [POLL_W-1:0]     poll_timer, poll_timer_next;
  logic                  wrote;

  logic [DELAY_W-1:0]    idle_reload;
  logic [DELAY_W-1:0]    flash_on_reload;
  logic [DELAY_W-1:0]    flash_off_reload;
  logic [INTERVAL_W-1:0] ramp_reload;
  logic [LEVEL_W-1:0]    floored_bl;

  assign idle_reload      = (cfg.idle_off_ms == '0) ? DELAY_W'(1) : cfg.idle_off_ms;
  assign flash_on_reload  = (cfg.flash_lit_ms == '0) ? DELAY_W'(1) : cfg.flash_lit_ms;
  assign flash_off_reload = (cfg.flash_period_ms > cfg.flash_lit_ms) ?
                            cfg.flash_period_ms - cfg.flash_lit_ms : DELAY_W'(1);
  assign ramp_reload      = (cfg.ramp_interval_ms == '0) ? INTERVAL_W'(1)
                                                         : cfg.ramp_interval_ms;
  assign floored_bl       = (item.backlight_level < cfg.min_level) ? cfg.min_level
                                                                   : item.backlight_level;

  always_comb begin
    logic [LEVEL_W:0] ramp_sum;
    logic [LEVEL_W-1:0] ramp_diff;

    caps_mode_next        = caps_mode;
    touch_held_next       = touch_held;
    ramp_rising_next      = ramp_rising;
    keys_seen_active_next = keys_seen_active;
    usb_flash_mode_next   = usb_flash_mode;
    flash_phase_on_next   = flash_phase_on;
    ramp_level_next       = ramp_level;
    shown_level_next      = shown_level;
    seen_backlight_next   = seen_backlight;
    led_reg_next          = led_reg;
    ramp_timer_next       = ramp_timer;
    idle_timer_next       = idle_timer;
    flash_timer_next      = flash_timer;
    poll_timer_next       = poll_timer;
    wrote                 = 1'b0;
    ramp_sum              = '0;
    ramp_diff             = '0;

    // caps lock edge
    if (item.caps_lock != caps_mode_next) begin
      caps_mode_next = item.caps_lock;
      if (item.caps_lock) begin
        ramp_level_next  = cfg.min_level;
        ramp_rising_next = 1'b1;
        ramp_timer_next  = INTERVAL_W'(1);
      end else begin
        ramp_timer_next = '0;
        if (item.touched) begin
          touch_held_next = 1'b1;
          if (keys_seen_active_next) shown_level_next = floored_bl;
          led_reg_next    = shown_level_next;
          wrote           = 1'b1;
          idle_timer_next = '0;
        end else begin
          touch_held_next = 1'b0;
          led_reg_next    = '0;
          wrote           = 1'b1;
        end
      end
    end

    // flash timer
    if (flash_timer_next != '0) begin
      flash_timer_next = flash_timer_next - DELAY_W'(1);
      if (flash_timer_next == '0) begin
        if (!usb_flash_mode_next) begin
          led_reg_next = '0;
          wrote        = 1'b1;
        end else begin
          flash_phase_on_next = !flash_phase_on_next;
          led_reg_next        = flash_phase_on_next ? cfg.max_level : '0;
          wrote               = 1'b1;
          flash_timer_next    = flash_phase_on_next ? flash_on_reload : flash_off_reload;
        end
      end
    end

    // idle timer
    if (idle_timer_next != '0) begin
      idle_timer_next = idle_timer_next - DELAY_W'(1);
      if (idle_timer_next == '0 && !caps_mode_next && !touch_held_next) begin
        led_reg_next = '0;
        wrote        = 1'b1;
      end
    end

    // breathing ramp timer
    if (ramp_timer_next != '0) begin
      ramp_timer_next = ramp_timer_next - INTERVAL_W'(1);
      if (ramp_timer_next == '0 && caps_mode_next) begin
        if (ramp_rising_next) begin
          ramp_sum = {1'b0, ramp_level_next} + {2'b00, cfg.ramp_step};
          if (ramp_sum >= {1'b0, cfg.max_level}) begin
            ramp_level_next  = cfg.max_level;
            ramp_rising_next = 1'b0;
          end else begin
            ramp_level_next = ramp_sum[LEVEL_W-1:0];
          end
        end else begin
          // saturate at zero before the turning point check
          ramp_diff = (ramp_level_next > {1'b0, cfg.ramp_step}) ?
                      ramp_level_next - {1'b0, cfg.ramp_step} : '0;
          if (ramp_diff <= cfg.low_level) begin
            ramp_level_next  = cfg.low_level;
            ramp_rising_next = 1'b1;
          end else begin
            ramp_level_next = ramp_diff;
          end
        end
        led_reg_next    = ramp_level_next;
        wrote           = 1'b1;
        ramp_timer_next = ramp_reload;
      end
    end

    // poll
    if (poll_timer == '0) begin
      poll_timer_next = POLL_RELOAD;
      if (item.usb_link) begin
        if (!usb_flash_mode_next) begin
          usb_flash_mode_next = 1'b1;
          flash_phase_on_next = 1'b0;
          flash_timer_next    = DELAY_W'(1);
        end
      end else begin
        if (usb_flash_mode_next) begin
          usb_flash_mode_next = 1'b0;
          flash_timer_next    = '0;
          led_reg_next        = '0;
          wrote               = 1'b1;
        end
        if (item.keys_active != keys_seen_active_next) begin
          keys_seen_active_next = item.keys_active;
          if (item.keys_active) seen_backlight_next = item.backlight_level;
        end
        if (!caps_mode_next && item.touched != touch_held_next) begin
          touch_held_next = item.touched;
          if (item.touched) begin
            if (keys_seen_active_next) shown_level_next = floored_bl;
            led_reg_next    = shown_level_next;
            wrote           = 1'b1;
            idle_timer_next = '0;
          end else begin
            idle_timer_next = idle_reload;
          end
        end
        if (!caps_mode_next && !touch_held_next && keys_seen_active_next &&
            item.backlight_level != seen_backlight_next) begin
          seen_backlight_next = item.backlight_level;
          if (item.backlight_level != '0) begin
            shown_level_next = floored_bl;
            led_reg_next     = floored_bl;
            wrote            = 1'b1;
            idle_timer_next  = idle_reload;
          end
        end
      end
    end else begin
      poll_timer_next = poll_timer - POLL_W'(1);
    end
  end

  assign result_next.led_level   = led_reg_next;
  assign result_next.led_written = wrote;

  always_ff @(posedge clk) begin
    if (rst) begin
      caps_mode        <= 1'b0;
      touch_held       <= 1'b0;
      ramp_rising      <= 1'b1;
      keys_seen_active <= 1'b0;
      usb_flash_mode   <= 1'b0;
      flash_phase_on   <= 1'b0;
      ramp_level       <= MIN_LEVEL_RST;
      shown_level      <= MAX_LEVEL_RST;
      seen_backlight   <= '0;
      led_reg          <= '0;
      ramp_timer       <= '0;
      idle_timer       <= '0;
      flash_timer      <= '0;
      poll_timer       <= '0;
    end else if (advance) begin
      caps_mode        <= caps_mode_next;
      touch_held       <= touch_held_next;
      ramp_rising      <= ramp_rising_next;
      keys_seen_active <= keys_seen_active_next;
      usb_flash_mode   <= usb_flash_mode_next;
      flash_phase_on   <= flash_phase_on_next;
      ramp_level       <= ramp_level_next;
      shown_level      <= shown_level_next;
      seen_backlight   <= seen_backlight_next;
      led_reg          <= led_reg_next;
      ramp_timer       <= ramp_timer_next;
      idle_timer       <= idle_timer_next;
      flash_timer      <= flash_timer_next;
      poll_timer       <= poll_timer_next;
    end
  end

  // the flash only runs while the usb link holds flash mode
  `ASSERT_ALWAYS(a_flash_needs_mode, clk, (flash_timer != '0) |-> usb_flash_mode,
                 "flash timer armed outside usb flash mode")
  // the ramp only runs while caps lock holds
  `ASSERT_ALWAYS(a_ramp_needs_caps, clk, (ramp_timer != '0) |-> caps_mode,
                 "ramp timer armed outside caps mode")
  // an item with no write keeps the level it found
  `ASSERT_CLK(a_level_held, clk, rst,
              (advance && !wrote) |-> (led_reg_next == led_reg),
              "led level changed without a write")

endmodule

`default_nettype wire

/* tb/indicator_led_mode_controller_tb.sv */
`timescale 1ns / 1ps

module indicator_led_mode_controller_tb;
  import ilmc_pkg::*;

  localparam int POLL_TICKS   = POLL_TICKS_DEFAULT;
  localparam int NUM_REGS     = 8;
  localparam int PHASE_ITEMS  = 225;
  localparam int STALL_CYCLES = 200;
  localparam int MAX_SHOWN    = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEM_W       = $bits(item_t);

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_ready;
  item_t                  item_in = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result_out;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          send_idle = 0;
  int          recv_idle = 0;
  bit          stall_req = 1'b0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  result_t led_expected[$];
  result_t level_want;

  // predictor state
  cfg_t         cfg_m;
  logic         caps_on, touch_on, ramp_up, keys_on, flash_mode, flash_lit, led_wr;
  logic [6:0]   ramp_lvl, shown_lvl, seen_bl, led_now;
  int unsigned  ramp_cnt, idle_cnt, flash_cnt, poll_cnt;

  indicator_led_mode_controller #(
    .POLL_TICKS(POLL_TICKS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item_in),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void led_model_reset();
    cfg_m.min_level        = MIN_LEVEL_RST;
    cfg_m.max_level        = MAX_LEVEL_RST;
    cfg_m.low_level        = LOW_LEVEL_RST;
    cfg_m.ramp_step        = RAMP_STEP_RST;
    cfg_m.ramp_interval_ms = RAMP_INTERVAL_RST;
    cfg_m.idle_off_ms      = IDLE_OFF_RST;
    cfg_m.flash_lit_ms     = FLASH_ON_RST;
    cfg_m.flash_period_ms  = FLASH_PERIOD_RST;
    caps_on    = 1'b0;
    touch_on   = 1'b0;
    ramp_up    = 1'b1;
    keys_on    = 1'b0;
    flash_mode = 1'b0;
    flash_lit  = 1'b0;
    led_wr     = 1'b0;
    ramp_lvl   = MIN_LEVEL_RST;
    shown_lvl  = MAX_LEVEL_RST;
    seen_bl    = '0;
    led_now    = '0;
    ramp_cnt   = 0;
    idle_cnt   = 0;
    flash_cnt  = 0;
    poll_cnt   = 0;
  endfunction

  function automatic void cfg_store(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_MIN_LEVEL:     cfg_m.min_level        = d[LEVEL_W-1:0];
      REG_MAX_LEVEL:     cfg_m.max_level        = d[LEVEL_W-1:0];
      REG_LOW_LEVEL:     cfg_m.low_level        = d[LEVEL_W-1:0];
      REG_RAMP_STEP:     cfg_m.ramp_step        = d[STEP_W-1:0];
      REG_RAMP_INTERVAL: cfg_m.ramp_interval_ms = d[INTERVAL_W-1:0];
      REG_IDLE_OFF:      cfg_m.idle_off_ms      = d[DELAY_W-1:0];
      REG_FLASH_ON:      cfg_m.flash_lit_ms     = d[DELAY_W-1:0];
      REG_FLASH_PERIOD:  cfg_m.flash_period_ms  = d[DELAY_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void led_put(int unsigned v);
    led_now = v[LEVEL_W-1:0];
    led_wr  = 1'b1;
  endfunction

  function automatic int unsigned one_if_zero(int unsigned d);
    return (d == 0) ? 1 : d;
  endfunction

  function automatic logic [6:0] at_min(logic [6:0] bl);
    return (bl < cfg_m.min_level) ? cfg_m.min_level : bl;
  endfunction

  function automatic void flash_expire();
    if (!flash_mode) begin
      led_put(0);
    end else begin
      flash_lit = !flash_lit;
      led_put(flash_lit ? cfg_m.max_level : 0);
      if (flash_lit) begin
        flash_cnt = one_if_zero(cfg_m.flash_lit_ms);
      end else if (cfg_m.flash_period_ms > cfg_m.flash_lit_ms) begin
        flash_cnt = cfg_m.flash_period_ms - cfg_m.flash_lit_ms;
      end else begin
        flash_cnt = 1;
      end
    end
  endfunction

  function automatic void ramp_expire();
    int unsigned n;
    if (caps_on) begin
      if (ramp_up) begin
        n = ramp_lvl + cfg_m.ramp_step;
        if (n >= cfg_m.max_level) begin
          n = cfg_m.max_level;
          ramp_up = 1'b0;
        end
      end else begin
        // saturate at zero before the turning point compare
        n = (ramp_lvl > cfg_m.ramp_step) ? ramp_lvl - cfg_m.ramp_step : 0;
        if (n <= cfg_m.low_level) begin
          n = cfg_m.low_level;
          ramp_up = 1'b1;
        end
      end
      ramp_lvl = n[LEVEL_W-1:0];
      led_put(ramp_lvl);
      ramp_cnt = one_if_zero(cfg_m.ramp_interval_ms);
    end
  endfunction

  function automatic void poll_inputs(item_t it);
    if (it.usb_link) begin
      if (!flash_mode) begin
        flash_mode = 1'b1;
        flash_lit  = 1'b0;
        flash_cnt  = 1;
      end
    end else begin
      if (flash_mode) begin
        flash_mode = 1'b0;
        flash_cnt  = 0;
        led_put(0);
      end
      if (it.keys_active != keys_on) begin
        keys_on = it.keys_active;
        if (it.keys_active) seen_bl = it.backlight_level;
      end
      if (!caps_on && it.touched != touch_on) begin
        touch_on = it.touched;
        if (it.touched) begin
          if (keys_on) shown_lvl = at_min(it.backlight_level);
          led_put(shown_lvl);
          idle_cnt = 0;
        end else begin
          idle_cnt = one_if_zero(cfg_m.idle_off_ms);
        end
      end
      if (!caps_on && !touch_on && it.backlight_level != seen_bl && keys_on) begin
        seen_bl = it.backlight_level;
        if (it.backlight_level > 0) begin
          shown_lvl = at_min(it.backlight_level);
          led_put(shown_lvl);
          idle_cnt = one_if_zero(cfg_m.idle_off_ms);
        end
      end
    end
  endfunction

  // one millisecond tick: caps edge, timers, then the poll
  function automatic result_t led_tick(item_t it);
    result_t r;
    led_wr = 1'b0;
    if (it.caps_lock != caps_on) begin
      caps_on = it.caps_lock;
      if (it.caps_lock) begin
        ramp_lvl = cfg_m.min_level;
        ramp_up  = 1'b1;
        ramp_cnt = 1;
      end else begin
        ramp_cnt = 0;
        touch_on = it.touched;
        if (it.touched) begin
          if (keys_on) shown_lvl = at_min(it.backlight_level);
          led_put(shown_lvl);
          idle_cnt = 0;
        end else begin
          led_put(0);
        end
      end
    end
    if (flash_cnt != 0) begin
      flash_cnt = flash_cnt - 1;
      if (flash_cnt == 0) flash_expire();
    end
    if (idle_cnt != 0) begin
      idle_cnt = idle_cnt - 1;
      if (idle_cnt == 0 && !caps_on && !touch_on) led_put(0);
    end
    if (ramp_cnt != 0) begin
      ramp_cnt = ramp_cnt - 1;
      if (ramp_cnt == 0) ramp_expire();
    end
    if (poll_cnt == 0) begin
      poll_cnt = POLL_TICKS - 1;
      poll_inputs(it);
    end else begin
      poll_cnt = poll_cnt - 1;
    end
    r.led_level   = led_now;
    r.led_written = led_wr;
    return r;
  endfunction

  function automatic item_t make_item(bit t, bit k, int unsigned bl, bit u, bit c);
    item_t x;
    x.touched         = t;
    x.keys_active     = k;
    x.backlight_level = bl[LEVEL_W-1:0];
    x.usb_link        = u;
    x.caps_lock       = c;
    return x;
  endfunction

  function automatic int unsigned random_backlight();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 0;
    if (pick < 25) return $urandom_range(127, 101);
    return $urandom_range(100, 1);
  endfunction

  // change one input as a user or host would, rarely the modes
  function automatic item_t nudge(item_t x);
    int unsigned f;
    f = $urandom_range(9);
    case (f) inside
      [0:2]:   x.touched = !x.touched;
      [3:4]:   x.keys_active = !x.keys_active;
      [5:7]:   x.backlight_level = LEVEL_W'(random_backlight());
      8:       x.usb_link = !x.usb_link;
      default: x.caps_lock = !x.caps_lock;
    endcase
    return x;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.min_level        = LEVEL_W'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                           : $urandom_range(40));
    c.max_level        = LEVEL_W'($urandom_range(127, 30));
    c.low_level        = LEVEL_W'($urandom_range(60));
    c.ramp_step        = STEP_W'(($urandom_range(9) == 0) ? $urandom_range(63)
                                                          : $urandom_range(25));
    c.ramp_interval_ms = INTERVAL_W'($urandom_range(6));
    c.idle_off_ms      = DELAY_W'($urandom_range(60));
    c.flash_lit_ms     = DELAY_W'($urandom_range(12));
    c.flash_period_ms  = DELAY_W'($urandom_range(20));
    return c;
  endfunction

  // bits above the register width are random and must be dropped
  function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned v, int w);
    logic [CFG_DATA_W-1:0] keep;
    keep = CFG_DATA_W'((1 << w) - 1);
    return (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(v) & keep);
  endfunction

  function automatic void report_miss(string msg);
    mismatches = mismatches + 1;
    if (mismatches <= MAX_SHOWN) $display("%0t: %s", $time, msg);
  endfunction

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_store(idx, d);
  endtask

  task automatic set_config(input cfg_t c);
    // an index past the register file is ignored
    cfg_write(CFG_INDEX_W'($urandom_range(2 ** CFG_INDEX_W - 1, NUM_REGS)),
              CFG_DATA_W'($urandom));
    cfg_write(REG_MIN_LEVEL, with_junk(c.min_level, LEVEL_W));
    cfg_write(REG_MAX_LEVEL, with_junk(c.max_level, LEVEL_W));
    cfg_write(REG_LOW_LEVEL, with_junk(c.low_level, LEVEL_W));
    cfg_write(REG_RAMP_STEP, with_junk(c.ramp_step, STEP_W));
    cfg_write(REG_RAMP_INTERVAL, with_junk(c.ramp_interval_ms, INTERVAL_W));
    cfg_write(REG_IDLE_OFF, with_junk(c.idle_off_ms, DELAY_W));
    cfg_write(REG_FLASH_ON, with_junk(c.flash_lit_ms, DELAY_W));
    cfg_write(REG_FLASH_PERIOD, with_junk(c.flash_period_ms, DELAY_W));
    cfg_valid <= 1'b0;
  endtask

  // valid is left high after the transfer so the next item can follow at once
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_in    <= it;
    do @(posedge clk); while (!item_ready);
    led_expected.push_back(led_tick(it));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (led_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_item(make_item(0, 0, 0, 0, 0));
    send_item(make_item(1, 1, 127, 1, 1));
    send_item(make_item(0, 0, 0, 0, 0));
    send_item(make_item(1, 0, 42, 0, 0));
    send_item(make_item(0, 1, 85, 0, 0));
    send_item(make_item(1, 1, 127, 0, 0));
    send_item(make_item(0, 1, 1, 0, 0));
    send_item(make_item(0, 0, 100, 0, 0));
  endtask

  task automatic test_special_cases();
    cfg_t c;
    wait_drained();
    c.min_level        = 5;
    c.max_level        = 127;
    c.low_level        = 0;
    c.ramp_step        = 63;
    c.ramp_interval_ms = 0;
    c.idle_off_ms      = 0;
    c.flash_lit_ms     = 3;
    c.flash_period_ms  = 2;
    set_config(c);
    // ramp clamps at the top, then falls through zero to the turning point
    repeat (6) send_item(make_item(0, 0, 0, 0, 1));
    // caps released while touched, the poll may write again in the same tick
    send_item(make_item(1, 1, 120, 0, 0));
    // on time longer than the period
    repeat (5) send_item(make_item(0, 0, 0, 1, 0));
    repeat (5) send_item(make_item(0, 1, 110, 0, 0));
  endtask

  task automatic test_backpressure();
    item_t it;
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    stall_req = 1'b1;
    it = make_item(1, 1, 60, 0, 0);
    repeat (40) begin
      if ($urandom_range(3) == 0) it = nudge(it);
      send_item(it);
    end
  endtask

  task automatic test_random_traffic();
    item_t       held, it;
    cfg_t        c;
    int unsigned pick;
    held = '0;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph == 1) c = '1;
      else if (ph == 3) c = '0;
      else c = random_settings();
      set_config(c);
      send_idle = (ph < 2) ? 29 : (ph < 4) ? 61 : 0;
      recv_idle = (ph < 2) ? 61 : (ph < 4) ? 29 : 0;
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          it = ITEM_W'($urandom);
        end else begin
          if (pick < 22) held = nudge(held);
          it = held;
        end
        send_item(it);
      end
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_req) begin
        result_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req = 1'b0;
      end
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (led_expected.size() == 0) begin
        report_miss($sformatf("result transfer with nothing pending: led_level %0d led_written %0b",
                              result_out.led_level, result_out.led_written));
      end else begin
        level_want = led_expected.pop_front();
        if (result_out.led_level !== level_want.led_level)
          report_miss($sformatf("led_level: expected %0d, got %0d",
                                level_want.led_level, result_out.led_level));
        if (result_out.led_written !== level_want.led_written)
          report_miss($sformatf("led_written: expected %0b, got %0b",
                                level_want.led_written, result_out.led_written));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("** indicator_led_mode_controller: FAILED **");
    $finish;
  end

  initial begin
    led_model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_special_cases();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0 && led_expected.size() == 0) begin
      $display("** indicator_led_mode_controller: PASSED **");
    end else begin
      $display("** indicator_led_mode_controller: FAILED **");
    end
    $finish;
  end

endmodule
